### rtl/core/utcc_pkg.sv
// Shared constants, types and small lookup functions for the Unix time / calendar converter.
// No dependencies; used by unix_time_calendar_convert.
package utcc_pkg;

  // Pipeline depth from input register to output register
  localparam int unsigned PipeDepth = 14;

  // Floor reciprocals: q_est = (x * Rcp) >> shift, low by at most one for x < 2**shift
  localparam logic [16:0] Rcp675  = 17'd99420;  // shift 26
  localparam logic [11:0] Rcp60a  = 12'd2184;   // shift 17
  localparam logic [5:0]  Rcp60b  = 6'd34;      // shift 11
  localparam logic [13:0] Rcp7    = 14'd9362;   // shift 16
  localparam logic [7:0]  Rcp1460 = 8'd179;     // shift 18
  localparam logic [9:0]  Rcp365  = 10'd718;    // shift 18
  localparam logic [3:0]  Rcp400  = 4'd10;      // shift 12

  // Day-number shift between 0000-03-01 and 1970-01-01, and one 400-year era
  localparam int unsigned EpochShift = 719468;
  localparam int unsigned DaysPerEra = 146097;

  // Time of day and weekday result
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } tod_t;

  // Unix seconds result with clamp flag
  typedef struct packed {
    logic [31:0] seconds;
    logic        clamped;
  } secs_t;

  // First day of month in a March-based year (0 is March)
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] ms;
    unique case (mp)
      4'd0:    ms = 9'd0;
      4'd1:    ms = 9'd31;
      4'd2:    ms = 9'd61;
      4'd3:    ms = 9'd92;
      4'd4:    ms = 9'd122;
      4'd5:    ms = 9'd153;
      4'd6:    ms = 9'd184;
      4'd7:    ms = 9'd214;
      4'd8:    ms = 9'd245;
      4'd9:    ms = 9'd275;
      4'd10:   ms = 9'd306;
      4'd11:   ms = 9'd337;
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

  // Century years within an era, yoe / 100 for yoe below 400
  function automatic logic [1:0] cent_count(input logic [8:0] yoe);
    logic [1:0] c;
    c = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    return c;
  endfunction

endpackage

### rtl/core/unix_time_calendar_convert.sv
// Unix seconds <-> local Gregorian calendar converter, fully pipelined.
// Throughput one item per cycle while a valid output is not stalled.
// The datapath has 14 stages; a stalled valid output freezes every stage.
// Reset (rst_ni low, asynchronous) clears all valid bits and the zone offset to 0.
// Depends on utcc_pkg (constants, reciprocals, month table).
module unix_time_calendar_convert (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic signed [4:0] cfg_zone_offset_hours_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [31:0]       utc_seconds_i,
  input  logic [11:0]       in_year_i,
  input  logic [3:0]        in_month_i,
  input  logic [4:0]        in_day_i,
  input  logic [4:0]        in_hour_i,
  input  logic [5:0]        in_minute_i,
  input  logic [5:0]        in_second_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       out_seconds_o,
  output logic [11:0]       out_year_o,
  output logic [3:0]        out_month_o,
  output logic [4:0]        out_day_o,
  output logic [4:0]        out_hour_o,
  output logic [5:0]        out_minute_o,
  output logic [5:0]        out_second_o,
  output logic [2:0]        out_weekday_o,
  output logic              out_of_range_o
);

  localparam int unsigned Depth = utcc_pkg::PipeDepth;

  // ---------------------------------------------------------------------------
  // Control: zone offset register and pipeline advance
  // ---------------------------------------------------------------------------
  logic signed [4:0] zone_q;
  logic [Depth:1]    vld_q;
  logic              adv;

  assign cfg_ready_o = 1'b1;
  assign adv         = !(vld_q[Depth] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
      vld_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        zone_q <= cfg_zone_offset_hours_i;
      end
      if (adv) begin
        vld_q <= {vld_q[Depth-1:1], in_valid_i};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 logic: bias local seconds, normalize calendar fields
  // ---------------------------------------------------------------------------
  logic signed [16:0] off3600;
  logic signed [34:0] u_s;
  logic [25:0]        x1_d;
  logic [6:0]         lo1_d;
  logic [3:0]         mon_c;
  logic [3:0]         mp_in;
  logic [11:0]        yy1_d;
  logic [8:0]         doyp1_d;
  logic [16:0]        tsum;
  logic signed [18:0] ts1_d;
  logic               flg1_d;

  assign off3600 = zone_q * 17'sd3600;
  // one day of bias keeps the local count non-negative
  assign u_s     = $signed({3'b000, utc_seconds_i}) + 35'sd86400 + 35'(off3600);
  assign x1_d    = u_s[32:7];
  assign lo1_d   = u_s[6:0];

  always_comb begin
    if (in_month_i == 4'd0) begin
      mon_c = 4'd1;
    end else if (in_month_i > 4'd12) begin
      mon_c = 4'd12;
    end else begin
      mon_c = in_month_i;
    end
  end

  assign mp_in   = (mon_c > 4'd2) ? mon_c - 4'd3 : mon_c + 4'd9;
  assign yy1_d   = (mon_c <= 4'd2) ? in_year_i - 12'd1 : in_year_i;
  assign doyp1_d = utcc_pkg::month_start(mp_in) + 9'(in_day_i);
  assign tsum    = 17'(in_hour_i) * 17'd3600 + 17'(in_minute_i) * 17'd60
                 + 17'(in_second_i);
  assign ts1_d   = $signed({2'b00, tsum}) - 19'(off3600);
  assign flg1_d  = in_year_i < 12'd1970;

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  logic               mode_q [1:Depth-1];
  // seconds -> calendar, day split
  logic [25:0]        x1_q, x2_q;
  logic [6:0]         lo1_q, lo2_q, lo3_q;
  logic [16:0]        qe2_q, qe3_q;
  logic [10:0]        r3_q;
  logic [16:0]        q4_q, rem4_q, rem5_q;
  // date
  logic [17:0]        doe_q [5:11];
  logic               era_q [5:13];
  logic [6:0]         ae6_q, ae7_q;
  logic [2:0]         c_q   [6:7];
  logic               e6_q, e7_q;
  logic [11:0]        ar7_q;
  logic [17:0]        n8_q, n9_q;
  logic [8:0]         ye9_q, ye10_q;
  logic [9:0]         yr10_q;
  logic [8:0]         yoe11_q, yoe12_q, yoe13_q;
  logic [8:0]         doy12_q, doy13_q;
  logic [3:0]         mp13_q;
  // time of day and weekday
  logic [10:0]        mte5_q, mte6_q, mt7_q, mt8_q;
  logic [6:0]         r60_6_q, mr9_q;
  logic [5:0]         sec7_q, sec8_q, sec9_q;
  logic [4:0]         he8_q, he9_q;
  logic [15:0]        w5_q;
  logic [12:0]        we5_q;
  logic [3:0]         wr6_q;
  logic [2:0]         wd7_q, wd8_q, wd9_q;
  utcc_pkg::tod_t     tod_q [10:13];
  // calendar -> seconds
  logic [11:0]        yy1_q, yy2_q;
  logic [8:0]         doyp_q [1:4];
  logic signed [18:0] ts_q   [1:8];
  logic               flg_q  [1:9];
  logic [3:0]         erae2_q, erae3_q, era4_q;
  logic [9:0]         yoe0_3_q;
  logic [8:0]         yoe4_q;
  logic [20:0]        e146_5_q, dp6_q;
  logic [18:0]        y365_5_q;
  logic signed [21:0] days7_q;
  logic signed [39:0] p8_q, t9_q;
  utcc_pkg::secs_t    sres_q [10:13];
  // output registers
  logic [31:0]        out_seconds_q;
  logic [11:0]        out_year_q;
  logic [3:0]         out_month_q;
  logic [4:0]         out_day_q;
  logic [4:0]         out_hour_q;
  logic [5:0]         out_minute_q;
  logic [5:0]         out_second_q;
  logic [2:0]         out_weekday_q;
  logic               out_of_range_q;

  // ---------------------------------------------------------------------------
  // Stage 2..4 logic: days = floor(u / 86400) via /128 then /675
  // ---------------------------------------------------------------------------
  logic [42:0] prod675;
  logic [16:0] qe2_d;
  logic [25:0] r675w;
  logic [10:0] r3_d;
  logic        ge675;
  logic [16:0] q4_d;
  logic [16:0] rem4_d;
  logic [9:0]  rc675;

  assign prod675 = 43'(x1_q) * 43'(utcc_pkg::Rcp675);
  assign qe2_d   = prod675[42:26];
  assign r675w   = x2_q - 26'(qe2_q) * 26'd675;
  assign r3_d    = r675w[10:0];
  assign ge675   = r3_q >= 11'd675;
  assign rc675   = ge675 ? 10'(r3_q - 11'd675) : r3_q[9:0];
  assign q4_d    = qe3_q + 17'(ge675);
  assign rem4_d  = {rc675, lo3_q};

  // Calendar side: era = yy / 400, yoe = yy % 400
  logic [15:0] prod400;
  logic [3:0]  erae2_d;
  logic [11:0] y400w;
  logic [9:0]  yoe0_3_d;
  logic        ge400;
  logic [3:0]  era4_d;
  logic [8:0]  yoe4_d;

  assign prod400  = 16'(yy1_q) * 16'(utcc_pkg::Rcp400);
  assign erae2_d  = prod400[15:12];
  assign y400w    = yy2_q - 12'(erae2_q) * 12'd400;
  assign yoe0_3_d = y400w[9:0];
  assign ge400    = yoe0_3_q >= 10'd400;
  assign era4_d   = erae3_q + 4'(ge400);
  assign yoe4_d   = ge400 ? 9'(yoe0_3_q - 10'd400) : yoe0_3_q[8:0];

  // ---------------------------------------------------------------------------
  // Stage 5 logic: day of era, time split start, weekday start
  // ---------------------------------------------------------------------------
  logic        era5_d;
  logic [17:0] doe5_d;
  logic [28:0] prod60a;
  logic [10:0] mte5_d;
  logic [15:0] w5_d;
  logic [29:0] prod7;
  logic [12:0] we5_d;
  logic [20:0] e146_5_d;
  logic [18:0] y365_5_d;

  // s = days + EpochShift lies in era 4 or 5
  assign era5_d   = q4_q >= 17'(5 * utcc_pkg::DaysPerEra - utcc_pkg::EpochShift + 1);
  assign doe5_d   = era5_d
                  ? 18'(q4_q) - 18'(5 * utcc_pkg::DaysPerEra - utcc_pkg::EpochShift + 1)
                  : 18'(q4_q) + 18'(utcc_pkg::EpochShift - 1 - 4 * utcc_pkg::DaysPerEra);
  assign prod60a  = 29'(rem4_q) * 29'(utcc_pkg::Rcp60a);
  assign mte5_d   = prod60a[27:17];
  // weekday = (days + 4) mod 7 = (q + 3) mod 7
  assign w5_d     = 16'(q4_q) + 16'd3;
  assign prod7    = 30'(w5_d) * 30'(utcc_pkg::Rcp7);
  assign we5_d    = prod7[28:16];
  assign e146_5_d = 21'(era4_q) * 21'(utcc_pkg::DaysPerEra);
  assign y365_5_d = 19'(yoe4_q) * 19'd365 + 19'(yoe4_q[8:2])
                  - 19'(utcc_pkg::cent_count(yoe4_q)) + 19'(doyp_q[4]);

  // ---------------------------------------------------------------------------
  // Stage 6..8 logic
  // ---------------------------------------------------------------------------
  logic [25:0] prod1460;
  logic [6:0]  ae6_d;
  logic [2:0]  c6_d;
  logic        e6_d;
  logic [16:0] r60w;
  logic [6:0]  r60_6_d;
  logic [15:0] w7w;
  logic [3:0]  wr6_d;
  logic [20:0] dp6_d;

  assign prod1460 = 26'(doe_q[5]) * 26'(utcc_pkg::Rcp1460);
  assign ae6_d    = prod1460[24:18];
  assign c6_d     = 3'(doe_q[5] >= 18'd36524) + 3'(doe_q[5] >= 18'd73048)
                  + 3'(doe_q[5] >= 18'd109572) + 3'(doe_q[5] >= 18'd146096);
  assign e6_d     = doe_q[5] == 18'd146096;
  assign r60w     = rem5_q - 17'(mte5_q) * 17'd60;
  assign r60_6_d  = r60w[6:0];
  assign w7w      = w5_q - 16'(we5_q) * 16'd7;
  assign wr6_d    = w7w[3:0];
  assign dp6_d    = e146_5_q + 21'(y365_5_q);

  logic [17:0]        a1460w;
  logic [11:0]        ar7_d;
  logic               ge60s;
  logic [5:0]         sec7_d;
  logic [10:0]        mt7_d;
  logic [2:0]         wd7_d;
  logic signed [21:0] days7_d;

  assign a1460w  = doe_q[6] - 18'(ae6_q) * 18'd1460;
  assign ar7_d   = a1460w[11:0];
  assign ge60s   = r60_6_q >= 7'd60;
  assign sec7_d  = ge60s ? 6'(r60_6_q - 7'd60) : r60_6_q[5:0];
  assign mt7_d   = mte6_q + 11'(ge60s);
  assign wd7_d   = (wr6_q >= 4'd7) ? 3'(wr6_q - 4'd7) : wr6_q[2:0];
  assign days7_d = $signed({1'b0, dp6_q}) - 22'(utcc_pkg::EpochShift + 1);

  logic [6:0]         a8;
  logic [17:0]        n8_d;
  logic [16:0]        prod60b;
  logic [4:0]         he8_d;
  logic signed [39:0] p8_d;

  assign a8      = ae7_q + 7'(ar7_q >= 12'd1460);
  assign n8_d    = doe_q[7] - 18'(a8) + 18'(c_q[7]) - 18'(e7_q);
  assign prod60b = 17'(mt7_q) * 17'(utcc_pkg::Rcp60b);
  assign he8_d   = prod60b[15:11];
  assign p8_d    = 40'(days7_q) * 40'sd86400;

  // ---------------------------------------------------------------------------
  // Stage 9..13 logic
  // ---------------------------------------------------------------------------
  logic [27:0]        prod365;
  logic [8:0]         ye9_d;
  logic [10:0]        m60w;
  logic [6:0]         mr9_d;
  logic signed [39:0] t9_d;

  assign prod365 = 28'(n8_q) * 28'(utcc_pkg::Rcp365);
  assign ye9_d   = prod365[26:18];
  assign m60w    = mt8_q - 11'(he8_q) * 11'd60;
  assign mr9_d   = m60w[6:0];
  assign t9_d    = p8_q + 40'(ts_q[8]);

  logic [17:0]     y365w;
  logic [9:0]      yr10_d;
  logic            ge60m;
  utcc_pkg::tod_t  tod10_d;
  utcc_pkg::secs_t sres10_d;

  assign y365w  = n9_q - 18'(ye9_q) * 18'd365;
  assign yr10_d = y365w[9:0];
  assign ge60m  = mr9_q >= 7'd60;

  always_comb begin
    tod10_d.hour    = he9_q + 5'(ge60m);
    tod10_d.minute  = ge60m ? 6'(mr9_q - 7'd60) : mr9_q[5:0];
    tod10_d.second  = sec9_q;
    tod10_d.weekday = wd9_q;
  end

  // Clamp to the 32-bit range; years before 1970 clamp to zero
  always_comb begin
    if (flg_q[9] || t9_q[39]) begin
      sres10_d.seconds = '0;
      sres10_d.clamped = 1'b1;
    end else if (|t9_q[38:32]) begin
      sres10_d.seconds = '1;
      sres10_d.clamped = 1'b1;
    end else begin
      sres10_d.seconds = t9_q[31:0];
      sres10_d.clamped = 1'b0;
    end
  end

  logic [8:0]  yoe11_d;
  logic [17:0] ydays;
  logic [17:0] doyw;
  logic [8:0]  doy12_d;
  logic [3:0]  mp13_d;

  assign yoe11_d = ye10_q + 9'(yr10_q >= 10'd365);
  assign ydays   = 18'(yoe11_q) * 18'd365 + 18'(yoe11_q[8:2])
                 - 18'(utcc_pkg::cent_count(yoe11_q));
  assign doyw    = doe_q[11] - ydays;
  assign doy12_d = doyw[8:0];

  // Month of a March-based year: count month starts at or below the day
  always_comb begin
    mp13_d = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy12_q >= utcc_pkg::month_start(4'(k))) begin
        mp13_d = mp13_d + 4'd1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 14 logic: final date fields and result select
  // ---------------------------------------------------------------------------
  logic [4:0]  day14;
  logic [3:0]  mon14;
  logic [11:0] year14;
  logic [8:0]  dayw;

  assign dayw   = doy13_q - utcc_pkg::month_start(mp13_q) + 9'd1;
  assign day14  = dayw[4:0];
  assign mon14  = (mp13_q < 4'd10) ? mp13_q + 4'd3 : mp13_q - 4'd9;
  assign year14 = 12'(yoe13_q) + (era_q[13] ? 12'd2000 : 12'd1600)
                + 12'(mp13_q >= 4'd10);

  // ---------------------------------------------------------------------------
  // Datapath registers, all advance together
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      mode_q[1]  <= req_type_i;
      x1_q       <= x1_d;
      lo1_q      <= lo1_d;
      yy1_q      <= yy1_d;
      doyp_q[1]  <= doyp1_d;
      ts_q[1]    <= ts1_d;
      flg_q[1]   <= flg1_d;
      for (int k = 2; k < Depth; k++) begin
        mode_q[k] <= mode_q[k-1];
      end
      for (int k = 2; k <= 4; k++) begin
        doyp_q[k] <= doyp_q[k-1];
      end
      for (int k = 2; k <= 8; k++) begin
        ts_q[k] <= ts_q[k-1];
      end
      for (int k = 2; k <= 9; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
      // stage 2
      qe2_q    <= qe2_d;
      x2_q     <= x1_q;
      lo2_q    <= lo1_q;
      erae2_q  <= erae2_d;
      yy2_q    <= yy1_q;
      // stage 3
      r3_q     <= r3_d;
      qe3_q    <= qe2_q;
      lo3_q    <= lo2_q;
      yoe0_3_q <= yoe0_3_d;
      erae3_q  <= erae2_q;
      // stage 4
      q4_q     <= q4_d;
      rem4_q   <= rem4_d;
      era4_q   <= era4_d;
      yoe4_q   <= yoe4_d;
      // stage 5
      era_q[5] <= era5_d;
      doe_q[5] <= doe5_d;
      mte5_q   <= mte5_d;
      rem5_q   <= rem4_q;
      w5_q     <= w5_d;
      we5_q    <= we5_d;
      e146_5_q <= e146_5_d;
      y365_5_q <= y365_5_d;
      for (int k = 6; k <= 11; k++) begin
        doe_q[k] <= doe_q[k-1];
      end
      for (int k = 6; k <= 13; k++) begin
        era_q[k] <= era_q[k-1];
      end
      // stage 6
      ae6_q    <= ae6_d;
      c_q[6]   <= c6_d;
      e6_q     <= e6_d;
      r60_6_q  <= r60_6_d;
      mte6_q   <= mte5_q;
      wr6_q    <= wr6_d;
      dp6_q    <= dp6_d;
      // stage 7
      ar7_q    <= ar7_d;
      ae7_q    <= ae6_q;
      c_q[7]   <= c_q[6];
      e7_q     <= e6_q;
      sec7_q   <= sec7_d;
      mt7_q    <= mt7_d;
      wd7_q    <= wd7_d;
      days7_q  <= days7_d;
      // stage 8
      n8_q     <= n8_d;
      he8_q    <= he8_d;
      mt8_q    <= mt7_q;
      sec8_q   <= sec7_q;
      wd8_q    <= wd7_q;
      p8_q     <= p8_d;
      // stage 9
      ye9_q    <= ye9_d;
      n9_q     <= n8_q;
      mr9_q    <= mr9_d;
      he9_q    <= he8_q;
      sec9_q   <= sec8_q;
      wd9_q    <= wd8_q;
      t9_q     <= t9_d;
      // stage 10
      yr10_q     <= yr10_d;
      ye10_q     <= ye9_q;
      tod_q[10]  <= tod10_d;
      sres_q[10] <= sres10_d;
      for (int k = 11; k <= 13; k++) begin
        tod_q[k]  <= tod_q[k-1];
        sres_q[k] <= sres_q[k-1];
      end
      // stage 11..13
      yoe11_q  <= yoe11_d;
      doy12_q  <= doy12_d;
      yoe12_q  <= yoe11_q;
      mp13_q   <= mp13_d;
      doy13_q  <= doy12_q;
      yoe13_q  <= yoe12_q;
      // stage 14: results, unused side reads zero
      if (mode_q[Depth-1]) begin
        out_seconds_q  <= sres_q[13].seconds;
        out_of_range_q <= sres_q[13].clamped;
        out_year_q     <= '0;
        out_month_q    <= '0;
        out_day_q      <= '0;
        out_hour_q     <= '0;
        out_minute_q   <= '0;
        out_second_q   <= '0;
        out_weekday_q  <= '0;
      end else begin
        out_seconds_q  <= '0;
        out_of_range_q <= 1'b0;
        out_year_q     <= year14;
        out_month_q    <= mon14;
        out_day_q      <= day14;
        out_hour_q     <= tod_q[13].hour;
        out_minute_q   <= tod_q[13].minute;
        out_second_q   <= tod_q[13].second;
        out_weekday_q  <= tod_q[13].weekday;
      end
    end
  end

  assign out_seconds_o  = out_seconds_q;
  assign out_year_o     = out_year_q;
  assign out_month_o    = out_month_q;
  assign out_day_o      = out_day_q;
  assign out_hour_o     = out_hour_q;
  assign out_minute_o   = out_minute_q;
  assign out_second_o   = out_second_q;
  assign out_weekday_o  = out_weekday_q;
  assign out_of_range_o = out_of_range_q;

endmodule

### tb/utcc_conversion_checker.sv
// Checker for the Unix time / calendar converter: predicts each result and compares it.
// Watches the config, request and result channels; no dependencies beyond the signals.
module utcc_conversion_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic signed [4:0] cfg_zone_offset_hours_i,
  // request channel
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              req_type_i,
  input  logic [31:0]       utc_seconds_i,
  input  logic [11:0]       in_year_i,
  input  logic [3:0]        in_month_i,
  input  logic [4:0]        in_day_i,
  input  logic [4:0]        in_hour_i,
  input  logic [5:0]        in_minute_i,
  input  logic [5:0]        in_second_i,
  // result channel
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [31:0]       out_seconds_i,
  input  logic [11:0]       out_year_i,
  input  logic [3:0]        out_month_i,
  input  logic [4:0]        out_day_i,
  input  logic [4:0]        out_hour_i,
  input  logic [5:0]        out_minute_i,
  input  logic [5:0]        out_second_i,
  input  logic [2:0]        out_weekday_i,
  input  logic              out_of_range_i,
  // status toward the testbench top
  output int                mismatch_count_o,
  output int                pending_results_o
);

  localparam longint SecsPerDay      = 86400;
  localparam longint DaysPer400Years = 400 * 365 + 97;
  localparam longint MarchEpochDays  = 719468;  // 0000-03-01 to 1970-01-01
  localparam longint MaxUnixSeconds  = 64'sd4294967295;

  typedef struct packed {
    logic [31:0] seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        clamped;
  } stamp_t;

  stamp_t expected_stamps[$];
  longint zone_hours;

  // Division rounding toward minus infinity
  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  // Day number relative to 1970-01-01 of a proleptic Gregorian date
  function automatic longint days_from_civil(input longint y, input longint m, input longint d);
    longint yy, era, yoe, mp, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = floor_quot(yy, 400);
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * DaysPer400Years + doe - MarchEpochDays;
  endfunction

  // Date of a day number; years run March to February internally
  function automatic void civil_from_days(input longint z, output longint y,
                                          output longint m, output longint d);
    longint s, era, doe, yoe, doy, mp;
    s   = z + MarchEpochDays;
    era = s / DaysPer400Years;
    doe = s - era * DaysPer400Years;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  // Expected result of one request under the current zone offset
  function automatic stamp_t convert_stamp(input logic req, input longint utc,
                                           input longint year, input longint month,
                                           input longint day, input longint hour,
                                           input longint minute, input longint second);
    stamp_t r;
    longint local_secs, days, rem, y, m, d, total;
    r = '0;
    if (!req) begin
      // seconds to local calendar; a negative offset may land on 1969-12-31
      local_secs = utc + zone_hours * 3600;
      days = floor_quot(local_secs, SecsPerDay);
      rem  = local_secs - days * SecsPerDay;
      civil_from_days(days, y, m, d);
      r.year    = 12'(y);
      r.month   = 4'(m);
      r.day     = 5'(d);
      r.hour    = 5'(rem / 3600);
      r.minute  = 6'((rem / 60) % 60);
      r.second  = 6'(rem % 60);
      r.weekday = 3'(((days + 4) % 7 + 7) % 7);
    end else begin
      // local calendar to seconds; month saturates, the rest counts linearly
      m = month;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      total = (days_from_civil(year, m, 1) + day - 1) * SecsPerDay
            + (hour - zone_hours) * 3600 + minute * 60 + second;
      if (year < 1970 || total < 0) begin
        r.seconds = '0;
        r.clamped = 1'b1;
      end else if (total > MaxUnixSeconds) begin
        r.seconds = '1;
        r.clamped = 1'b1;
      end else begin
        r.seconds = 32'(total);
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count_o++;
    end
  endtask

  // Track config and request transfers, score each result transfer
  always @(posedge clk_i) begin
    stamp_t want;
    if (!rst_ni) begin
      zone_hours = 0;
      expected_stamps.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) zone_hours = cfg_zone_offset_hours_i;
      if (in_valid_i && !in_stall_i)
        expected_stamps.push_back(convert_stamp(req_type_i, utc_seconds_i, in_year_i,
                                                in_month_i, in_day_i, in_hour_i,
                                                in_minute_i, in_second_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_stamps.size() == 0) begin
          $error("result transfer with no request outstanding (out_seconds %0d)",
                 out_seconds_i);
          mismatch_count_o++;
        end else begin
          want = expected_stamps.pop_front();
          check_field("out_seconds", want.seconds, out_seconds_i);
          check_field("out_year", want.year, out_year_i);
          check_field("out_month", want.month, out_month_i);
          check_field("out_day", want.day, out_day_i);
          check_field("out_hour", want.hour, out_hour_i);
          check_field("out_minute", want.minute, out_minute_i);
          check_field("out_second", want.second, out_second_i);
          check_field("out_weekday", want.weekday, out_weekday_i);
          check_field("out_of_range", want.clamped, out_of_range_i);
        end
      end
    end
    pending_results_o = expected_stamps.size();
  end

endmodule

### tb/tb_unix_time_calendar_convert.sv
// Testbench top for unix_time_calendar_convert: clock, reset, stimulus and verdict.
// Depends on utcc_pkg, the converter RTL and utcc_conversion_checker.
module tb_unix_time_calendar_convert;

  localparam int HoldCycles = 300;

  typedef struct packed {
    logic        req_type;
    logic [31:0] utc_seconds;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
  } conv_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic signed [4:0] cfg_zone_offset_hours_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              req_type_i = 1'b0;
  logic [31:0]       utc_seconds_i = '0;
  logic [11:0]       in_year_i = '0;
  logic [3:0]        in_month_i = '0;
  logic [4:0]        in_day_i = '0;
  logic [4:0]        in_hour_i = '0;
  logic [5:0]        in_minute_i = '0;
  logic [5:0]        in_second_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [31:0]       out_seconds_o;
  logic [11:0]       out_year_o;
  logic [3:0]        out_month_o;
  logic [4:0]        out_day_o;
  logic [4:0]        out_hour_o;
  logic [5:0]        out_minute_o;
  logic [5:0]        out_second_o;
  logic [2:0]        out_weekday_o;
  logic              out_of_range_o;

  int mismatch_count;
  int pending_results;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;

  unix_time_calendar_convert dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_zone_offset_hours_i,
    .in_valid_i, .in_stall_o, .req_type_i, .utc_seconds_i, .in_year_i, .in_month_i,
    .in_day_i, .in_hour_i, .in_minute_i, .in_second_i,
    .out_valid_o, .out_stall_i, .out_seconds_o, .out_year_o, .out_month_o, .out_day_o,
    .out_hour_o, .out_minute_o, .out_second_o, .out_weekday_o, .out_of_range_o
  );

  utcc_conversion_checker checker_i (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_i             (cfg_ready_o),
    .cfg_zone_offset_hours_i (cfg_zone_offset_hours_i),
    .in_valid_i              (in_valid_i),
    .in_stall_i              (in_stall_o),
    .req_type_i              (req_type_i),
    .utc_seconds_i           (utc_seconds_i),
    .in_year_i               (in_year_i),
    .in_month_i              (in_month_i),
    .in_day_i                (in_day_i),
    .in_hour_i               (in_hour_i),
    .in_minute_i             (in_minute_i),
    .in_second_i             (in_second_i),
    .out_valid_i             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_seconds_i           (out_seconds_o),
    .out_year_i              (out_year_o),
    .out_month_i             (out_month_o),
    .out_day_i               (out_day_o),
    .out_hour_i              (out_hour_o),
    .out_minute_i            (out_minute_o),
    .out_second_i            (out_second_o),
    .out_weekday_i           (out_weekday_o),
    .out_of_range_i          (out_of_range_o),
    .mismatch_count_o        (mismatch_count),
    .pending_results_o       (pending_results)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side stall: random, or one long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Every field random; callers overwrite what they care about
  function automatic conv_req_t noise_request();
    conv_req_t r;
    r.req_type    = 1'($urandom);
    r.utc_seconds = $urandom;
    r.in_year     = 12'($urandom);
    r.in_month    = 4'($urandom);
    r.in_day      = 5'($urandom);
    r.in_hour     = 5'($urandom);
    r.in_minute   = 6'($urandom);
    r.in_second   = 6'($urandom);
    return r;
  endfunction

  function automatic conv_req_t seconds_req(input logic [31:0] secs);
    conv_req_t r;
    r = noise_request();
    r.req_type = 1'b0;
    r.utc_seconds = secs;
    return r;
  endfunction

  function automatic conv_req_t calendar_req(input int y, input int mo, input int d,
                                             input int h, input int mi, input int s);
    conv_req_t r;
    r = noise_request();
    r.req_type  = 1'b1;
    r.in_year   = 12'(y);
    r.in_month  = 4'(mo);
    r.in_day    = 5'(d);
    r.in_hour   = 5'(h);
    r.in_minute = 6'(mi);
    r.in_second = 6'(s);
    return r;
  endfunction

  // Mostly plausible timestamps and dates, some near leap and range edges, some noise
  function automatic conv_req_t random_request();
    conv_req_t r;
    int unsigned pick;
    logic [31:0] anchor;
    r = noise_request();
    pick = $urandom_range(0, 19);
    if (pick < 4) begin
      r.req_type = 1'b0;
    end else if (pick < 8) begin
      case ($urandom_range(0, 5))
        0:       anchor = 32'd0;
        1:       anchor = 32'd951782400;   // 2000-02-29
        2:       anchor = 32'd4107456000;  // 2100-02-28
        3:       anchor = 32'd2147483647;
        4:       anchor = 32'd4102444800;  // 2100-01-01
        default: anchor = 32'hFFFF_FFFF;
      endcase
      r.req_type = 1'b0;
      r.utc_seconds = anchor + 32'($urandom_range(0, 400000)) - 32'd200000;
    end else if (pick < 17) begin
      r.req_type = 1'b1;
      if ($urandom_range(0, 3) == 0)
        r.in_year = $urandom_range(0, 1) ? 12'($urandom_range(2099, 2106))
                                         : 12'($urandom_range(1970, 1972));
      else
        r.in_year = 12'($urandom_range(1970, 2106));
      r.in_month  = 4'($urandom_range(1, 12));
      r.in_day    = 5'($urandom_range(1, 31));
      r.in_hour   = 5'($urandom_range(0, 23));
      r.in_minute = 6'($urandom_range(0, 59));
      r.in_second = 6'($urandom_range(0, 59));
    end else begin
      r.req_type = 1'b1;
    end
    return r;
  endfunction

  // One request transfer, preceded by random idle cycles; returns at a falling edge
  task automatic send_request(input conv_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= r.req_type;
    utc_seconds_i <= r.utc_seconds;
    in_year_i     <= r.in_year;
    in_month_i    <= r.in_month;
    in_day_i      <= r.in_day;
    in_hour_i     <= r.in_hour;
    in_minute_i   <= r.in_minute;
    in_second_i   <= r.in_second;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Offset write once the pipeline has drained
  task automatic write_zone(input int hours);
    in_valid_i <= 1'b0;
    wait (pending_results == 0);
    repeat (utcc_pkg::PipeDepth + 2) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_zone_offset_hours_i <= 5'(hours);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int phase_zones [5] = '{-12, 14, -16, 15, 0};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: UTC, epoch and 32-bit ends, leap days, clamps, out-of-range fields
    write_zone(0);
    send_request(seconds_req(32'd0));
    send_request(seconds_req(32'hFFFF_FFFF));
    send_request(seconds_req(32'd951782400));
    send_request(seconds_req(32'd4107542399));
    send_request(seconds_req(32'd4107542400));
    send_request(calendar_req(1970, 1, 1, 0, 0, 0));
    send_request(calendar_req(2106, 2, 7, 6, 28, 15));
    send_request(calendar_req(2106, 2, 7, 6, 28, 16));
    send_request(calendar_req(1969, 12, 31, 23, 59, 59));
    send_request(calendar_req(0, 0, 0, 0, 0, 0));
    send_request(calendar_req(4095, 15, 31, 31, 63, 63));
    send_request(calendar_req(2000, 0, 0, 0, 0, 0));
    send_request(calendar_req(2000, 13, 31, 30, 63, 63));
    send_request(calendar_req(2100, 2, 29, 12, 0, 0));

    // Most negative offset: day borrowed before the epoch
    write_zone(-16);
    send_request(seconds_req(32'd0));
    send_request(seconds_req(32'hFFFF_FFFF));
    send_request(calendar_req(1970, 1, 1, 0, 0, 0));
    send_request(calendar_req(2106, 2, 7, 0, 0, 0));

    // Most positive offset: calendar runs past 2106, negative totals clamp
    write_zone(15);
    send_request(seconds_req(32'd0));
    send_request(seconds_req(32'hFFFF_FFFF));
    send_request(calendar_req(1970, 1, 1, 0, 0, 0));
    send_request(calendar_req(1970, 1, 1, 15, 0, 0));
    send_request(calendar_req(2106, 2, 7, 21, 28, 15));

    // Random phases, each setting an offset and one of four idle and stall patterns
    for (int p = 0; p < 8; p++) begin
      write_zone((p < 5) ? phase_zones[p] : int'($signed(5'($urandom_range(0, 31)))));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 80; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 80; end
        default: begin idle_pct = 14; stall_pct <= 14; end
      endcase
      // long result hold-off while requests keep coming, to back up the pipeline
      if (p == 4) hold_req <= 1'b1;
      repeat (80) send_request(random_request());
    end

    in_valid_i <= 1'b0;
    wait (pending_results == 0);
    repeat (2 * utcc_pkg::PipeDepth) @(negedge clk_i);
    if (mismatch_count == 0 && pending_results == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
